// ===== hw/rtl/cra_pkg.sv =====
`timescale 1ns / 1ps
// Shared types, command codes and the step sequences of the rational ALU.
package cra_pkg;

  localparam int DEF_WORD_BITS = 64;
  localparam int UPC_BITS = 5;
  localparam logic [UPC_BITS-1:0] UPC_DONE = '1;

  localparam logic [1:0] CMD_MUL_INT = 2'd0;
  localparam logic [1:0] CMD_MUL_RAT = 2'd1;
  localparam logic [1:0] CMD_ADD_INT = 2'd2;
  localparam logic [1:0] CMD_ADD_RAT = 2'd3;

  typedef enum logic [2:0] {
    OP_COPY,
    OP_ADD,
    OP_MUL,
    OP_DIV,
    OP_GCD
  } op_t;

  typedef enum logic [3:0] {
    R_AN,
    R_AD,
    R_BN,
    R_BD,
    R_N,
    R_D,
    R_P,
    R_Q,
    R_G,
    R_BDR
  } reg_t;

  typedef enum logic [2:0] {
    BR_NONE,
    BR_OK,
    BR_OVF,
    BR_GONE,
    BR_ALWAYS
  } br_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_ISSUE,
    S_WAIT,
    S_EMIT
  } state_t;

  typedef struct packed {
    op_t                 op;
    reg_t                a;
    reg_t                b;
    reg_t                dst;
    logic                clr;
    br_t                 br;
    logic [UPC_BITS-1:0] tgt;
  } uinst_t;

  typedef struct packed {
    logic load;
    logic start;
    op_t  op;
    reg_t a;
    reg_t b;
    reg_t dst;
    logic clr;
    logic emit;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
    logic ovf;
    logic g_one;
  } dp_status_t;

  function automatic uinst_t mk(op_t op, reg_t a, reg_t b, reg_t dst, logic clr,
                                br_t br, logic [UPC_BITS-1:0] tgt);
    uinst_t u;
    u.op  = op;
    u.a   = a;
    u.b   = b;
    u.dst = dst;
    u.clr = clr;
    u.br  = br;
    u.tgt = tgt;
    return u;
  endfunction

  // One retry of the rational product: numerator, then denominator.
  function automatic uinst_t mul_rat_retry(logic [UPC_BITS-1:0] step, reg_t x, reg_t y,
                                           logic last);
    uinst_t u;
    case (step)
      5'd0:    u = mk(OP_GCD, x, y, R_G, 1'b0, BR_NONE, UPC_DONE);
      5'd1:    u = mk(OP_DIV, x, x, x, 1'b0, BR_NONE, UPC_DONE);
      5'd2:    u = mk(OP_DIV, y, y, y, 1'b0, BR_NONE, UPC_DONE);
      5'd3:    u = mk(OP_MUL, R_AN, R_BN, R_N, 1'b1, BR_NONE, UPC_DONE);
      default: u = mk(OP_MUL, R_AD, R_BD, R_D, 1'b0, last ? BR_ALWAYS : BR_OK, UPC_DONE);
    endcase
    return u;
  endfunction

  function automatic uinst_t ucode(logic [1:0] cmd, logic [UPC_BITS-1:0] upc);
    uinst_t u;
    u = mk(OP_COPY, R_N, R_N, R_N, 1'b0, BR_ALWAYS, UPC_DONE);
    case (cmd)
      CMD_MUL_INT: begin
        case (upc)
          5'd0: u = mk(OP_COPY, R_AD, R_AD, R_D, 1'b0, BR_NONE, UPC_DONE);
          5'd1: u = mk(OP_MUL, R_AN, R_BN, R_N, 1'b1, BR_OK, UPC_DONE);
          5'd2: u = mk(OP_GCD, R_D, R_BN, R_G, 1'b0, BR_NONE, UPC_DONE);
          5'd3: u = mk(OP_DIV, R_BN, R_BN, R_BN, 1'b0, BR_NONE, UPC_DONE);
          5'd4: u = mk(OP_DIV, R_D, R_D, R_D, 1'b0, BR_NONE, UPC_DONE);
          5'd5: u = mk(OP_MUL, R_AN, R_BN, R_N, 1'b1, BR_OK, UPC_DONE);
          5'd6: u = mk(OP_GCD, R_AN, R_D, R_G, 1'b0, BR_NONE, UPC_DONE);
          5'd7: u = mk(OP_DIV, R_AN, R_AN, R_AN, 1'b0, BR_NONE, UPC_DONE);
          5'd8: u = mk(OP_DIV, R_D, R_D, R_D, 1'b0, BR_NONE, UPC_DONE);
          5'd9: u = mk(OP_MUL, R_AN, R_BN, R_N, 1'b1, BR_ALWAYS, UPC_DONE);
          default: u = mk(OP_COPY, R_N, R_N, R_N, 1'b0, BR_ALWAYS, UPC_DONE);
        endcase
      end
      CMD_MUL_RAT: begin
        if (upc == 5'd0) begin
          u = mk(OP_MUL, R_AN, R_BN, R_N, 1'b1, BR_NONE, UPC_DONE);
        end else if (upc == 5'd1) begin
          u = mk(OP_MUL, R_AD, R_BD, R_D, 1'b0, BR_OK, UPC_DONE);
        end else if (upc < 5'd7) begin
          u = mul_rat_retry(upc - 5'd2, R_AN, R_BD, 1'b0);
        end else if (upc < 5'd12) begin
          u = mul_rat_retry(upc - 5'd7, R_BN, R_AD, 1'b0);
        end else if (upc < 5'd17) begin
          u = mul_rat_retry(upc - 5'd12, R_AN, R_AD, 1'b0);
        end else if (upc < 5'd22) begin
          u = mul_rat_retry(upc - 5'd17, R_BN, R_BD, 1'b1);
        end
      end
      CMD_ADD_INT: begin
        case (upc)
          5'd0: u = mk(OP_MUL, R_BN, R_AD, R_P, 1'b1, BR_OK, 5'd5);
          5'd1: u = mk(OP_GCD, R_AN, R_AD, R_G, 1'b0, BR_GONE, UPC_DONE);
          5'd2: u = mk(OP_DIV, R_AD, R_AD, R_AD, 1'b0, BR_NONE, UPC_DONE);
          5'd3: u = mk(OP_MUL, R_BN, R_AD, R_P, 1'b1, BR_NONE, UPC_DONE);
          5'd4: u = mk(OP_DIV, R_AN, R_AN, R_AN, 1'b0, BR_OVF, UPC_DONE);
          5'd5: u = mk(OP_COPY, R_AD, R_AD, R_D, 1'b0, BR_NONE, UPC_DONE);
          5'd6: u = mk(OP_ADD, R_AN, R_P, R_N, 1'b0, BR_ALWAYS, UPC_DONE);
          default: u = mk(OP_COPY, R_N, R_N, R_N, 1'b0, BR_ALWAYS, UPC_DONE);
        endcase
      end
      default: begin
        case (upc)
          5'd0:  u = mk(OP_MUL, R_AD, R_BD, R_D, 1'b1, BR_NONE, UPC_DONE);
          5'd1:  u = mk(OP_MUL, R_AN, R_BD, R_P, 1'b0, BR_NONE, UPC_DONE);
          5'd2:  u = mk(OP_MUL, R_BN, R_AD, R_Q, 1'b0, BR_NONE, UPC_DONE);
          5'd3:  u = mk(OP_ADD, R_P, R_Q, R_N, 1'b0, BR_OK, UPC_DONE);
          5'd4:  u = mk(OP_GCD, R_AN, R_AD, R_G, 1'b0, BR_NONE, UPC_DONE);
          5'd5:  u = mk(OP_DIV, R_AN, R_AN, R_AN, 1'b0, BR_NONE, UPC_DONE);
          5'd6:  u = mk(OP_DIV, R_AD, R_AD, R_AD, 1'b0, BR_NONE, UPC_DONE);
          5'd7:  u = mk(OP_GCD, R_BN, R_BD, R_G, 1'b0, BR_NONE, UPC_DONE);
          5'd8:  u = mk(OP_DIV, R_BN, R_BN, R_BN, 1'b0, BR_NONE, UPC_DONE);
          5'd9:  u = mk(OP_DIV, R_BD, R_BD, R_BD, 1'b0, BR_NONE, UPC_DONE);
          5'd10: u = mk(OP_COPY, R_BD, R_BD, R_BDR, 1'b0, BR_NONE, UPC_DONE);
          5'd11: u = mk(OP_GCD, R_AD, R_BD, R_G, 1'b0, BR_NONE, UPC_DONE);
          5'd12: u = mk(OP_DIV, R_AD, R_AD, R_AD, 1'b0, BR_NONE, UPC_DONE);
          5'd13: u = mk(OP_DIV, R_BD, R_BD, R_BD, 1'b0, BR_NONE, UPC_DONE);
          5'd14: u = mk(OP_MUL, R_AD, R_BDR, R_D, 1'b1, BR_NONE, UPC_DONE);
          5'd15: u = mk(OP_MUL, R_AN, R_BD, R_P, 1'b0, BR_NONE, UPC_DONE);
          5'd16: u = mk(OP_MUL, R_BN, R_AD, R_Q, 1'b0, BR_NONE, UPC_DONE);
          5'd17: u = mk(OP_ADD, R_P, R_Q, R_N, 1'b0, BR_ALWAYS, UPC_DONE);
          default: u = mk(OP_COPY, R_N, R_N, R_N, 1'b0, BR_ALWAYS, UPC_DONE);
        endcase
      end
    endcase
    return u;
  endfunction

endpackage

// ===== hw/rtl/cra_dp.sv =====
`timescale 1ns / 1ps
// Datapath: operand registers and the shared multiply, divide, gcd and add units.
module cra_dp #(
  parameter int WORD_BITS = cra_pkg::DEF_WORD_BITS
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic [63:0]          a_num,
  input  logic [63:0]          a_den,
  input  logic [63:0]          b_num,
  input  logic [63:0]          b_den,
  input  cra_pkg::dp_cmd_t     cmd,
  output cra_pkg::dp_status_t  sts,
  output logic [WORD_BITS-1:0] res_num,
  output logic [WORD_BITS-1:0] res_den,
  output logic                 res_ovf
);

  localparam int W  = WORD_BITS;
  localparam int CW = $clog2(W + 1);
  localparam int KW = $clog2(W);

  logic [W-1:0] an, ad, bn, bd, n, d, p, q, g, bdr;
  logic [W-1:0] opa, opb;
  logic         ovf_acc;
  logic         busy, done;
  cra_pkg::op_t  op_r;
  cra_pkg::reg_t dst_r;
  logic [CW-1:0] cnt;
  logic [W-1:0]  ux, uy;
  logic [2*W-1:0] acc;
  logic [KW-1:0]  k;

  logic [W:0]     add_sum;
  logic [W:0]     msum;
  logic [2*W-1:0] mul_next;
  logic [W:0]     dtmp, ddif;
  logic           dge;
  logic [2*W-1:0] div_next;
  logic [W-1:0]   gor, gres;
  logic           gfin;
  logic           last;

  logic          wr_en;
  cra_pkg::reg_t wr_dst;
  logic [W-1:0]  wr_val;

  always_comb begin
    case (cmd.a)
      cra_pkg::R_AN:  opa = an;
      cra_pkg::R_AD:  opa = ad;
      cra_pkg::R_BN:  opa = bn;
      cra_pkg::R_BD:  opa = bd;
      cra_pkg::R_N:   opa = n;
      cra_pkg::R_D:   opa = d;
      cra_pkg::R_P:   opa = p;
      cra_pkg::R_Q:   opa = q;
      cra_pkg::R_G:   opa = g;
      cra_pkg::R_BDR: opa = bdr;
      default:        opa = '0;
    endcase
    case (cmd.b)
      cra_pkg::R_AN:  opb = an;
      cra_pkg::R_AD:  opb = ad;
      cra_pkg::R_BN:  opb = bn;
      cra_pkg::R_BD:  opb = bd;
      cra_pkg::R_N:   opb = n;
      cra_pkg::R_D:   opb = d;
      cra_pkg::R_P:   opb = p;
      cra_pkg::R_Q:   opb = q;
      cra_pkg::R_G:   opb = g;
      cra_pkg::R_BDR: opb = bdr;
      default:        opb = '0;
    endcase
  end

  assign add_sum = {1'b0, opa} + {1'b0, opb};

  // Shift-add multiply: the low half holds the multiplier as it drains out.
  assign msum     = {1'b0, acc[2*W-1:W]} + (acc[0] ? {1'b0, ux} : {(W+1){1'b0}});
  assign mul_next = {msum, acc[W-1:1]};

  // Restoring divide: the high half is the remainder, the low half the quotient.
  assign dtmp     = {acc[2*W-1:W], acc[W-1]};
  assign dge      = dtmp >= {1'b0, ux};
  assign ddif     = dtmp - {1'b0, ux};
  assign div_next = {(dge ? ddif[W-1:0] : dtmp[W-1:0]), acc[W-2:0], dge};

  // Binary gcd; a gcd of two zeros counts as one.
  assign gor  = ux | uy;
  assign gfin = (ux == '0) || (uy == '0);
  assign gres = (gor == '0) ? W'(1) : (gor << k);

  assign last = (cnt == CW'(1));

  always_comb begin
    wr_en  = 1'b0;
    wr_dst = cmd.dst;
    wr_val = opa;
    if (cmd.start) begin
      case (cmd.op)
        cra_pkg::OP_COPY: begin
          wr_en = 1'b1;
        end
        cra_pkg::OP_ADD: begin
          wr_en  = 1'b1;
          wr_val = add_sum[W-1:0];
        end
        default: wr_en = 1'b0;
      endcase
    end else if (busy) begin
      wr_dst = dst_r;
      case (op_r)
        cra_pkg::OP_MUL: begin
          wr_en  = last;
          wr_val = mul_next[W-1:0];
        end
        cra_pkg::OP_DIV: begin
          wr_en  = last;
          wr_val = div_next[W-1:0];
        end
        cra_pkg::OP_GCD: begin
          wr_en  = gfin;
          wr_dst = cra_pkg::R_G;
          wr_val = gres;
        end
        default: wr_en = 1'b0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      an <= a_num[W-1:0];
      ad <= a_den[W-1:0];
      bn <= b_num[W-1:0];
      bd <= b_den[W-1:0];
    end else if (wr_en) begin
      case (wr_dst)
        cra_pkg::R_AN:  an  <= wr_val;
        cra_pkg::R_AD:  ad  <= wr_val;
        cra_pkg::R_BN:  bn  <= wr_val;
        cra_pkg::R_BD:  bd  <= wr_val;
        cra_pkg::R_N:   n   <= wr_val;
        cra_pkg::R_D:   d   <= wr_val;
        cra_pkg::R_P:   p   <= wr_val;
        cra_pkg::R_Q:   q   <= wr_val;
        cra_pkg::R_G:   g   <= wr_val;
        cra_pkg::R_BDR: bdr <= wr_val;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy    <= 1'b0;
      done    <= 1'b0;
      ovf_acc <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        case (cmd.op)
          cra_pkg::OP_COPY: done <= 1'b1;
          cra_pkg::OP_ADD: begin
            done    <= 1'b1;
            ovf_acc <= (ovf_acc & ~cmd.clr) | add_sum[W];
          end
          default: begin
            busy <= 1'b1;
            if (cmd.clr) begin
              ovf_acc <= 1'b0;
            end
          end
        endcase
      end else if (busy) begin
        case (op_r)
          cra_pkg::OP_MUL: begin
            if (last) begin
              busy    <= 1'b0;
              done    <= 1'b1;
              ovf_acc <= ovf_acc | (|mul_next[2*W-1:W]);
            end
          end
          cra_pkg::OP_DIV: begin
            if (last) begin
              busy <= 1'b0;
              done <= 1'b1;
            end
          end
          default: begin
            if (gfin) begin
              busy <= 1'b0;
              done <= 1'b1;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      op_r  <= cmd.op;
      dst_r <= cmd.dst;
      cnt   <= CW'(W);
      k     <= '0;
      ux    <= (cmd.op == cra_pkg::OP_DIV) ? g : opa;
      uy    <= opb;
      acc   <= {{W{1'b0}}, ((cmd.op == cra_pkg::OP_DIV) ? opa : opb)};
    end else if (busy) begin
      cnt <= cnt - CW'(1);
      case (op_r)
        cra_pkg::OP_MUL: acc <= mul_next;
        cra_pkg::OP_DIV: acc <= div_next;
        default: begin
          if (!gfin) begin
            if (!ux[0] && !uy[0]) begin
              ux <= ux >> 1;
              uy <= uy >> 1;
              k  <= k + KW'(1);
            end else if (!ux[0]) begin
              ux <= ux >> 1;
            end else if (!uy[0]) begin
              uy <= uy >> 1;
            end else if (ux >= uy) begin
              ux <= ux - uy;
            end else begin
              uy <= uy - ux;
            end
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      res_num <= ovf_acc ? '0 : n;
      res_den <= ovf_acc ? '0 : d;
      res_ovf <= ovf_acc;
    end
  end

  assign sts.done  = done;
  assign sts.ovf   = ovf_acc;
  assign sts.g_one = (g == W'(1));

endmodule

// ===== hw/rtl/cra_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: request handshake, step sequencer and result valid flag.
module cra_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  logic [1:0]          command,
  output logic                res_valid,
  input  logic                res_stall,
  output cra_pkg::dp_cmd_t    dp_cmd,
  input  cra_pkg::dp_status_t dp_sts
);

  cra_pkg::state_t state, state_next;
  logic [cra_pkg::UPC_BITS-1:0] upc, upc_next, upc_step;
  logic [1:0] cmd_r;
  cra_pkg::uinst_t ui;
  logic take;
  logic accept;
  logic emit_ok;

  assign ui      = cra_pkg::ucode(cmd_r, upc);
  assign accept  = req_valid && !req_stall;
  assign emit_ok = !res_valid || !res_stall;

  always_comb begin
    case (ui.br)
      cra_pkg::BR_OK:     take = !dp_sts.ovf;
      cra_pkg::BR_OVF:    take = dp_sts.ovf;
      cra_pkg::BR_GONE:   take = dp_sts.g_one;
      cra_pkg::BR_ALWAYS: take = 1'b1;
      default:            take = 1'b0;
    endcase
    upc_step = take ? ui.tgt : upc + 1'b1;
  end

  always_comb begin
    state_next = state;
    upc_next   = upc;
    case (state)
      cra_pkg::S_IDLE: begin
        if (req_valid) begin
          state_next = cra_pkg::S_ISSUE;
          upc_next   = '0;
        end
      end
      cra_pkg::S_ISSUE: state_next = cra_pkg::S_WAIT;
      cra_pkg::S_WAIT: begin
        if (dp_sts.done) begin
          upc_next   = upc_step;
          state_next = (upc_step == cra_pkg::UPC_DONE) ? cra_pkg::S_EMIT : cra_pkg::S_ISSUE;
        end
      end
      cra_pkg::S_EMIT: begin
        if (emit_ok) begin
          state_next = cra_pkg::S_IDLE;
        end
      end
      default: state_next = cra_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    req_stall    = (state != cra_pkg::S_IDLE);
    dp_cmd.load  = (state == cra_pkg::S_IDLE) && req_valid;
    dp_cmd.start = (state == cra_pkg::S_ISSUE);
    dp_cmd.op    = ui.op;
    dp_cmd.a     = ui.a;
    dp_cmd.b     = ui.b;
    dp_cmd.dst   = ui.dst;
    dp_cmd.clr   = ui.clr;
    dp_cmd.emit  = (state == cra_pkg::S_EMIT) && emit_ok;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= cra_pkg::S_IDLE;
      upc       <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      upc   <= upc_next;
      if (dp_cmd.emit) begin
        res_valid <= 1'b1;
      end else if (!res_stall) begin
        res_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      cmd_r <= command;
    end
  end

endmodule

// ===== hw/rtl/checked_rational_arith.sv =====
`timescale 1ns / 1ps
// Top level of the checked rational ALU: controller, datapath and assertions.
// Steps: a request runs a sequence of datapath steps (multiply, divide, gcd, copy or add),
// and the length of a gcd step depends on the operands. A direct fit takes 2 to 4 steps,
// the longest chain 22.
// Throughput: one request at a time; the next is taken while a result waits.
// Reset: synchronous, clears the sequencer and the result valid flag.
module checked_rational_arith #(
  parameter int WORD_BITS = cra_pkg::DEF_WORD_BITS
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        req_valid,
  output logic        req_stall,
  input  logic [1:0]  command,
  input  logic [63:0] a_num,
  input  logic [63:0] a_den,
  input  logic [63:0] b_num,
  input  logic [63:0] b_den,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [63:0] result_num,
  output logic [63:0] result_den,
  output logic        overflow
);

  cra_pkg::dp_cmd_t    dp_cmd;
  cra_pkg::dp_status_t dp_sts;
  logic [WORD_BITS-1:0] rnum, rden;

  cra_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .command   (command),
    .res_valid (res_valid),
    .res_stall (res_stall),
    .dp_cmd    (dp_cmd),
    .dp_sts    (dp_sts)
  );

  cra_dp #(
    .WORD_BITS (WORD_BITS)
  ) u_dp (
    .clk     (clk),
    .rst     (rst),
    .a_num   (a_num),
    .a_den   (a_den),
    .b_num   (b_num),
    .b_den   (b_den),
    .cmd     (dp_cmd),
    .sts     (dp_sts),
    .res_num (rnum),
    .res_den (rden),
    .res_ovf (overflow)
  );

  assign result_num = 64'(rnum);
  assign result_den = 64'(rden);

  // A taken request keeps the block busy until its result has been formed.
  assert property (@(posedge clk) disable iff (rst)
    req_valid && !req_stall |=> req_stall)
    else $error("request taken while block stayed open");

  // An overflowed result carries a zero fraction.
  assert property (@(posedge clk) disable iff (rst)
    res_valid && overflow |-> result_num == 64'd0 && result_den == 64'd0)
    else $error("overflow result with nonzero fraction");

  // A fresh result only appears after the block has been working on a request.
  assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(req_stall))
    else $error("result appeared without a request in progress");

  // The datapath never reports a finished step, nor loads operands, while a new one is issued.
  assert property (@(posedge clk) disable iff (rst)
    dp_cmd.start |-> !dp_sts.done && !dp_cmd.load)
    else $error("step issued while datapath still reporting");

endmodule
